FILE: hdl/ihtk_pkg.sv
`timescale 1ns / 1ps
// Shared sizes for the indexed max-heap block.
// No dependencies.
package ihtk_pkg;
    localparam int ENTRIES = 32;
    localparam int IDW     = $clog2(ENTRIES);
    localparam int CNTW    = $clog2(ENTRIES + 1);
    localparam int KEYW    = 32;
    localparam int TOPW    = 6;
    localparam int IDW2    = IDW + 2;

    localparam logic REQ_UPDATE = 1'b0;
    localparam logic REQ_QUERY  = 1'b1;
endpackage

FILE: hdl/indexed_max_heap_top_k.sv
`timescale 1ns / 1ps
// Indexed max-heap of entry ids with top-k query, top level.
// Depends on ihtk_pkg.
//
// Updates and queries are taken one at a time; the input is ready only when the
// sequencer is idle. An update climbs the heap from the entry's position; a key
// change of a present entry then also descends (one heap read, one key read and
// one compare per child, all on memories with registered reads). A query first
// copies the heap into a scratch memory, then reports each item by taking the
// root and sifting the last entry down. An empty answer is sent with is_empty
// set and no data. Results wait in an output register, so a new item is taken
// while the last result is still unread.
module indexed_max_heap_top_k (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    // [4:0] entry_id, [36:5] new_key, [42:37] top_count, [43] take_all
    input  logic [47:0] i_s_axis_tdata,
    // [0] req_type
    input  logic        i_s_axis_tuser,
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    // [4:0] entry_id_out, [36:5] key_out
    output logic [39:0] o_m_axis_tdata,
    output logic        o_m_axis_tlast,
    // [0] is_empty
    output logic        o_m_axis_tuser
);
    localparam int IDW  = ihtk_pkg::IDW;
    localparam int CNTW = ihtk_pkg::CNTW;
    localparam int KEYW = ihtk_pkg::KEYW;
    localparam int IDW2 = ihtk_pkg::IDW2;
    localparam int N    = ihtk_pkg::ENTRIES;

    localparam logic [4:0] S_IDLE  = 5'd0;
    localparam logic [4:0] S_ULK   = 5'd1;
    localparam logic [4:0] S_UP    = 5'd2;
    localparam logic [4:0] S_UPK   = 5'd3;
    localparam logic [4:0] S_UPC   = 5'd4;
    localparam logic [4:0] S_UPE   = 5'd5;
    localparam logic [4:0] S_DN    = 5'd6;
    localparam logic [4:0] S_DLK   = 5'd7;
    localparam logic [4:0] S_DLC   = 5'd8;
    localparam logic [4:0] S_DRK   = 5'd9;
    localparam logic [4:0] S_DRC   = 5'd10;
    localparam logic [4:0] S_DDEC  = 5'd11;
    localparam logic [4:0] S_CPR   = 5'd12;
    localparam logic [4:0] S_CPW   = 5'd13;
    localparam logic [4:0] S_POP   = 5'd14;
    localparam logic [4:0] S_POPK  = 5'd15;
    localparam logic [4:0] S_POPO  = 5'd16;
    localparam logic [4:0] S_POPL  = 5'd17;
    localparam logic [4:0] S_POPLK = 5'd18;
    localparam logic [4:0] S_EMPTY = 5'd19;

    // memories
    logic [IDW-1:0]  hmem [N];
    logic [IDW-1:0]  smem [N];
    logic [KEYW-1:0] kmem [N];
    logic [IDW-1:0]  pmem [N];
    logic [IDW-1:0]  hq, sq, pq;
    logic [KEYW-1:0] kq;

    logic [4:0]      r_state, n_state;
    logic            r_isq, n_isq;
    logic            r_down, n_down;
    logic [IDW-1:0]  r_pos, n_pos;
    logic [IDW-1:0]  r_cur_id, n_cur_id;
    logic [KEYW-1:0] r_cur_key, n_cur_key;
    logic [IDW-1:0]  r_oid, n_oid;
    logic            r_best_mv, n_best_mv;
    logic [IDW-1:0]  r_best_pos, n_best_pos;
    logic [IDW-1:0]  r_best_id, n_best_id;
    logic [KEYW-1:0] r_best_key, n_best_key;
    logic [CNTW-1:0] r_n, n_n;
    logic [CNTW-1:0] r_k, n_k;
    logic [CNTW-1:0] r_i, n_i;
    logic [CNTW-1:0] r_cnt, n_cnt;
    logic [N-1:0]    r_present;
    logic            set_pres;

    logic            r_ov;
    logic [IDW-1:0]  r_out_id;
    logic [KEYW-1:0] r_out_key;
    logic            r_out_last, r_out_empty;
    logic            out_load, out_empty, out_free;
    logic [IDW-1:0]  out_id;
    logic [KEYW-1:0] out_key;
    logic            out_last;

    logic            acc;
    logic            in_req, in_all;
    logic [IDW-1:0]  in_id;
    logic [KEYW-1:0] in_key;
    logic [5:0]      in_top;
    logic [CNTW-1:0] kk;

    logic [IDW-1:0]  hd;
    logic [IDW-1:0]  ha, pa, ka;
    logic            wr, h_we, s_we, p_we, k_we, cp_we;
    logic [IDW-1:0]  w_addr, w_data, p_wa, p_wd;
    logic [IDW-1:0]  par;
    logic [IDW2-1:0] lw, rw, nw;

    assign in_req = i_s_axis_tuser;
    assign in_id  = i_s_axis_tdata[IDW-1:0];
    assign in_key = i_s_axis_tdata[36:5];
    assign in_top = i_s_axis_tdata[42:37];
    assign in_all = i_s_axis_tdata[43];

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign acc      = i_s_axis_tvalid && o_s_axis_tready;
    assign out_free = !r_ov || i_m_axis_tready;

    assign hd  = r_isq ? sq : hq;
    assign par = (r_pos - 1'b1) >> 1;
    assign lw  = {1'b0, r_pos, 1'b1};
    assign rw  = lw + 1'b1;
    assign nw  = IDW2'(r_n);
    assign kk  = (in_all || ({{(7 - CNTW){1'b0}}, r_cnt} < {1'b0, in_top})) ?
                 r_cnt : CNTW'(in_top);

    always_comb begin
        n_state    = r_state;
        n_isq      = r_isq;
        n_down     = r_down;
        n_pos      = r_pos;
        n_cur_id   = r_cur_id;
        n_cur_key  = r_cur_key;
        n_oid      = r_oid;
        n_best_mv  = r_best_mv;
        n_best_pos = r_best_pos;
        n_best_id  = r_best_id;
        n_best_key = r_best_key;
        n_n        = r_n;
        n_k        = r_k;
        n_i        = r_i;
        n_cnt      = r_cnt;
        set_pres   = 1'b0;
        wr         = 1'b0;
        cp_we      = 1'b0;
        p_we       = 1'b0;
        k_we       = 1'b0;
        w_addr     = r_pos;
        w_data     = r_cur_id;
        p_wa       = r_cur_id;
        p_wd       = r_pos;
        ha         = r_pos;
        ka         = r_oid;
        pa         = in_id;
        out_load   = 1'b0;
        out_empty  = 1'b0;
        out_id     = r_oid;
        out_key    = kq;
        out_last   = (r_k == CNTW'(1));
        case (r_state)
            S_IDLE: begin
                if (acc) begin
                    if (in_req == ihtk_pkg::REQ_UPDATE) begin
                        k_we      = 1'b1;
                        n_cur_id  = in_id;
                        n_cur_key = in_key;
                        n_isq     = 1'b0;
                        n_state   = S_ULK;
                    end else if (kk == '0) begin
                        n_state = S_EMPTY;
                    end else begin
                        n_k     = kk;
                        n_n     = r_cnt;
                        n_i     = '0;
                        n_isq   = 1'b1;
                        n_state = S_CPR;
                    end
                end
            end
            S_ULK: begin
                if (r_present[r_cur_id]) begin
                    if ({1'b0, pq} >= r_cnt) begin
                        n_state = S_IDLE;
                    end else begin
                        n_pos   = pq;
                        n_down  = 1'b1;
                        n_n     = r_cnt;
                        n_state = S_UP;
                    end
                end else if (r_cnt == CNTW'(N)) begin
                    n_state = S_IDLE;
                end else begin
                    set_pres = 1'b1;
                    n_pos    = r_cnt[IDW-1:0];
                    n_cnt    = r_cnt + 1'b1;
                    n_n      = r_cnt + 1'b1;
                    n_down   = 1'b0;
                    n_state  = S_UP;
                end
            end
            S_UP: begin
                ha = par;
                n_state = (r_pos == '0) ? S_UPE : S_UPK;
            end
            S_UPK: begin
                n_oid   = hd;
                ka      = hd;
                n_state = S_UPC;
            end
            S_UPC: begin
                if (kq < r_cur_key) begin
                    wr      = 1'b1;
                    w_data  = r_oid;
                    p_we    = !r_isq;
                    p_wa    = r_oid;
                    n_pos   = par;
                    n_state = S_UP;
                end else begin
                    n_state = S_UPE;
                end
            end
            S_UPE: begin
                if (r_down) begin
                    n_state = S_DN;
                end else begin
                    wr      = 1'b1;
                    p_we    = !r_isq;
                    n_state = S_IDLE;
                end
            end
            S_DN: begin
                ha = lw[IDW-1:0];
                if (lw >= nw) begin
                    wr      = 1'b1;
                    p_we    = !r_isq;
                    n_state = r_isq ? S_POP : S_IDLE;
                end else begin
                    n_state = S_DLK;
                end
            end
            S_DLK: begin
                n_oid   = hd;
                ka      = hd;
                n_state = S_DLC;
            end
            S_DLC: begin
                ha = rw[IDW-1:0];
                if (kq > r_cur_key) begin
                    n_best_mv  = 1'b1;
                    n_best_pos = lw[IDW-1:0];
                    n_best_id  = r_oid;
                    n_best_key = kq;
                end else begin
                    n_best_mv  = 1'b0;
                    n_best_key = r_cur_key;
                end
                n_state = (rw < nw) ? S_DRK : S_DDEC;
            end
            S_DRK: begin
                n_oid   = hd;
                ka      = hd;
                n_state = S_DRC;
            end
            S_DRC: begin
                if (kq > r_best_key) begin
                    n_best_mv  = 1'b1;
                    n_best_pos = rw[IDW-1:0];
                    n_best_id  = r_oid;
                end
                n_state = S_DDEC;
            end
            S_DDEC: begin
                wr   = 1'b1;
                p_we = !r_isq;
                if (!r_best_mv) begin
                    n_state = r_isq ? S_POP : S_IDLE;
                end else begin
                    w_data  = r_best_id;
                    p_wa    = r_best_id;
                    n_pos   = r_best_pos;
                    n_state = S_DN;
                end
            end
            S_CPR: begin
                ha      = r_i[IDW-1:0];
                n_state = S_CPW;
            end
            S_CPW: begin
                cp_we   = 1'b1;
                w_addr  = r_i[IDW-1:0];
                w_data  = hq;
                n_i     = r_i + 1'b1;
                n_state = (r_i + 1'b1 == r_n) ? S_POP : S_CPR;
            end
            S_POP: begin
                ha      = '0;
                n_state = S_POPK;
            end
            S_POPK: begin
                n_oid   = hd;
                ka      = hd;
                n_state = S_POPO;
            end
            S_POPO: begin
                ha = IDW'(r_n - 1'b1);
                if (out_free) begin
                    out_load = 1'b1;
                    n_k      = r_k - 1'b1;
                    n_state  = (r_k == CNTW'(1)) ? S_IDLE : S_POPL;
                end
            end
            S_POPL: begin
                n_cur_id = hd;
                ka       = hd;
                n_state  = S_POPLK;
            end
            S_POPLK: begin
                n_cur_key = kq;
                n_n       = r_n - 1'b1;
                n_pos     = '0;
                n_state   = S_DN;
            end
            S_EMPTY: begin
                if (out_free) begin
                    out_load  = 1'b1;
                    out_empty = 1'b1;
                    out_id    = '0;
                    out_key   = '0;
                    out_last  = 1'b0;
                    n_state   = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign h_we = wr && !r_isq;
    assign s_we = (wr && r_isq) || cp_we;

    always_ff @(posedge i_clk) begin
        if (h_we) begin
            hmem[w_addr] <= w_data;
        end
        hq <= hmem[ha];
        if (s_we) begin
            smem[w_addr] <= w_data;
        end
        sq <= smem[ha];
        if (k_we) begin
            kmem[in_id] <= in_key;
        end
        kq <= kmem[ka];
        if (p_we) begin
            pmem[p_wa] <= p_wd;
        end
        pq <= pmem[pa];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_cnt     <= '0;
            r_present <= '0;
            r_ov      <= 1'b0;
            r_isq     <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_isq   <= n_isq;
            if (set_pres) begin
                r_present[r_cur_id] <= 1'b1;
            end
            if (out_load) begin
                r_ov <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_ov <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_down     <= n_down;
        r_pos      <= n_pos;
        r_cur_id   <= n_cur_id;
        r_cur_key  <= n_cur_key;
        r_oid      <= n_oid;
        r_best_mv  <= n_best_mv;
        r_best_pos <= n_best_pos;
        r_best_id  <= n_best_id;
        r_best_key <= n_best_key;
        r_n        <= n_n;
        r_k        <= n_k;
        r_i        <= n_i;
        if (out_load) begin
            r_out_id    <= out_id;
            r_out_key   <= out_key;
            r_out_last  <= out_last;
            r_out_empty <= out_empty;
        end
    end

    assign o_m_axis_tvalid = r_ov;
    assign o_m_axis_tdata  = {3'b000, r_out_key, r_out_id};
    assign o_m_axis_tlast  = r_out_last;
    assign o_m_axis_tuser  = r_out_empty;

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CNTW'(N))
        else $error("heap count above capacity");

    a_cnt_mono: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) |-> r_cnt >= $past(r_cnt))
        else $error("heap count decreased");

    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        acc |=> !o_s_axis_tready)
        else $error("ready right after accepted item");

    a_empty_fmt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ov && r_out_empty) |-> (!r_out_last && r_out_key == '0 && r_out_id == '0))
        else $error("empty result carries data");
endmodule
